// File: rtl/core/psle_pkg.sv
package psle_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int SCORE_BITS_DEF = 16;
  localparam int CNT_W = 7;
  localparam int SUM_W = 22;
  localparam int AVG_W = 24;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SORT   = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_BAD   = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;
endpackage

// File: rtl/core/psle_div.sv
module psle_div #(
  parameter int NW = 30,
  parameter int DW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] mag;
  logic [DW:0]   rem;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], mag[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(NW);
        neg <= num[NW-1];
        mag <= num[NW-1] ? NW'(-num) : NW'(num);
        rem <= '0;
      end else if (run) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          mag <= {mag[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          mag <= {mag[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed(mag) : $signed(mag);
endmodule

// File: rtl/core/positional_score_list_engine.sv
// Command engine over an ordered list held in one single-port-read memory.
// Raise start for one cycle while busy is low; busy then stays high until the
// result beat, shown for exactly one cycle with done high (it cannot be held).
// A memory read registers the chosen address and then the read data.
// Each command takes a walk over the list: insert/delete shift entries one at
// a time (address, wait, write), a read waits on the memory, sort is an
// insertion sort (address, wait and load to fetch each key, wait and compare
// per comparison, one write to place it), and statistics take a pass over the
// list, when it is not empty, followed by a bit-serial divide for the
// average. No clearing pass.
module positional_score_list_engine #(
  parameter int CAPACITY   = psle_pkg::CAPACITY_DEF,
  parameter int SCORE_BITS = psle_pkg::SCORE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    action,
  input  logic [6:0]                    position,
  input  logic signed [15:0]            score_in,
  output logic                          busy,
  output logic                          done,
  output logic [1:0]                    status,
  output logic signed [15:0]            score_out,
  output logic [psle_pkg::CNT_W-1:0]    entry_total,
  output logic signed [15:0]            max_score,
  output logic signed [psle_pkg::SUM_W-1:0] score_sum,
  output logic signed [psle_pkg::AVG_W-1:0] average_q8
);
  localparam int AW = $clog2(CAPACITY);
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int SW = SCORE_BITS + NW + 1;
  localparam int QW = SW + 8;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_WT, S_INS_WR, S_DEL_RD, S_DEL_WT, S_DEL_WR,
    S_SRT_KEY, S_SRT_KW, S_SRT_KL, S_SRT_W, S_SRT_CMP, S_SRT_PUT,
    S_RD_WAIT, S_RD_GET, S_ST_RD, S_ST_ACC, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic signed [SCORE_BITS-1:0] mem [CAPACITY];
  logic signed [SCORE_BITS-1:0] rdata, key, ins_val, mx;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic signed [SCORE_BITS-1:0] wdata;
  logic [NW-1:0] count, idx, jdx, stop;
  logic [1:0]    st;
  logic signed [SCORE_BITS-1:0] rv;
  logic signed [SW-1:0] sum;
  logic          div_go, div_done;
  logic signed [QW-1:0] quo;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  psle_div #(.NW(QW), .DW(NW)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .num({sum, 8'd0}), .den(count),
    .done(div_done), .quo(quo)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      we     <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      we     <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            st <= psle_pkg::ST_DONE;
            rv <= '0;
            ins_val <= SCORE_BITS'(score_in);
            unique case (action)
              psle_pkg::ACT_INSERT: begin
                if (count >= NW'(CAPACITY)) begin
                  st <= psle_pkg::ST_BAD; idx <= '0; state <= S_ST_RD;
                end else if (count == '0) begin
                  we <= 1'b1; waddr <= '0; wdata <= SCORE_BITS'(score_in);
                  count <= NW'(1); idx <= '0; state <= S_ST_RD;
                end else if (position == 7'd0 || 32'(position) > 32'(count) + 1) begin
                  st <= psle_pkg::ST_BAD; idx <= '0; state <= S_ST_RD;
                end else begin
                  idx <= count; stop <= NW'(position - 7'd1);
                  state <= S_INS_RD;
                end
              end
              psle_pkg::ACT_DELETE: begin
                if (count == '0) begin
                  st <= psle_pkg::ST_EMPTY; idx <= '0; state <= S_ST_RD;
                end else if (position == 7'd0 || 32'(position) > 32'(count)) begin
                  st <= psle_pkg::ST_BAD; idx <= '0; state <= S_ST_RD;
                end else begin
                  idx <= NW'(position); state <= S_DEL_RD;
                end
              end
              psle_pkg::ACT_SORT: begin
                idx <= NW'(1); state <= S_SRT_KEY;
              end
              default: begin
                if (count == '0) begin
                  st <= psle_pkg::ST_EMPTY; idx <= '0; state <= S_ST_RD;
                end else if (position == 7'd0 || 32'(position) > 32'(count)) begin
                  st <= psle_pkg::ST_BAD; idx <= '0; state <= S_ST_RD;
                end else begin
                  raddr <= AW'(position - 7'd1); state <= S_RD_WAIT;
                end
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          state <= S_RD_GET;
        end
        S_RD_GET: begin
          rv <= rdata; idx <= '0; state <= S_ST_RD;
        end
        S_INS_RD: begin
          if (idx == stop) begin
            we <= 1'b1; waddr <= AW'(stop); wdata <= ins_val;
            count <= count + 1'b1; idx <= '0; state <= S_ST_RD;
          end else begin
            raddr <= AW'(idx - 1'b1); state <= S_INS_WT;
          end
        end
        S_INS_WT: begin
          state <= S_INS_WR;
        end
        S_INS_WR: begin
          we <= 1'b1; waddr <= AW'(idx); wdata <= rdata;
          idx <= idx - 1'b1; state <= S_INS_RD;
        end
        S_DEL_RD: begin
          if (idx >= count) begin
            count <= count - 1'b1; idx <= '0; state <= S_ST_RD;
          end else begin
            raddr <= AW'(idx); state <= S_DEL_WT;
          end
        end
        S_DEL_WT: begin
          state <= S_DEL_WR;
        end
        S_DEL_WR: begin
          we <= 1'b1; waddr <= AW'(idx - 1'b1); wdata <= rdata;
          idx <= idx + 1'b1; state <= S_DEL_RD;
        end
        S_SRT_KEY: begin
          if (idx >= count) begin
            idx <= '0; state <= S_ST_RD;
          end else begin
            raddr <= AW'(idx); state <= S_SRT_KW;
          end
        end
        S_SRT_KW: begin
          state <= S_SRT_KL;
        end
        S_SRT_KL: begin
          key <= rdata; jdx <= idx;
          raddr <= AW'(idx - 1'b1); state <= S_SRT_W;
        end
        S_SRT_W: begin
          state <= S_SRT_CMP;
        end
        S_SRT_CMP: begin
          if (rdata > key) begin
            we <= 1'b1; waddr <= AW'(jdx); wdata <= rdata;
            jdx <= jdx - 1'b1;
            if (jdx == NW'(1)) begin
              state <= S_SRT_PUT;
            end else begin
              raddr <= AW'(jdx - 2'd2); state <= S_SRT_W;
            end
          end else begin
            state <= S_SRT_PUT;
          end
        end
        S_SRT_PUT: begin
          we <= 1'b1; waddr <= AW'(jdx); wdata <= key;
          idx <= idx + 1'b1; state <= S_SRT_KEY;
        end
        S_ST_RD: begin
          sum <= '0; mx <= '0;
          raddr <= '0; jdx <= '0;
          if (count == '0) state <= S_OUT;
          else state <= S_ST_ACC;
        end
        S_ST_ACC: begin
          if (idx == '0) begin
            idx <= NW'(1);
            raddr <= AW'(1);
          end else begin
            sum <= sum + SW'(rdata);
            if (idx == NW'(1) || rdata > mx) mx <= rdata;
            if (idx == count) begin
              div_go <= 1'b1; state <= S_DIV;
            end else begin
              idx <= idx + 1'b1;
              raddr <= AW'(idx + 1'b1);
            end
          end
        end
        S_DIV: begin
          if (div_done) state <= S_OUT;
        end
        default: begin
          done <= 1'b1;
          status <= st;
          score_out <= 16'(rv);
          entry_total <= psle_pkg::CNT_W'(count);
          max_score <= 16'(mx);
          score_sum <= psle_pkg::SUM_W'(sum);
          average_q8 <= (count == '0) ? '0 : psle_pkg::AVG_W'(quo);
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy);
  assert property (@(posedge clk) disable iff (rst) count <= NW'(CAPACITY))
    else $error("count overflow");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("command not taken");
endmodule

// File: tb/tb_positional_score_list_engine.sv
module tb_positional_score_list_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import psle_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int STALL_LIMIT = 40000;

  typedef struct packed {
    logic [1:0] act;
    logic [6:0] pos;
    logic signed [15:0] score;
  } cmd_t;

  typedef struct packed {
    logic [1:0] st;
    logic signed [15:0] rd;
    logic [6:0] cnt;
    logic signed [15:0] mx;
    logic signed [21:0] sum;
    logic signed [23:0] avg;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] action = '0;
  logic [6:0] position = '0;
  logic signed [15:0] score_in = '0;
  logic busy, done;
  logic [1:0] status;
  logic signed [15:0] score_out, max_score;
  logic [CNT_W-1:0] entry_total;
  logic signed [SUM_W-1:0] score_sum;
  logic signed [AVG_W-1:0] average_q8;

  positional_score_list_engine dut (
    .clk, .rst, .start, .action, .position, .score_in, .busy, .done, .status,
    .score_out, .entry_total, .max_score, .score_sum, .average_q8
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cmd_t pending_cmds[$];
  reply_t expected_replies[$];
  logic signed [15:0] list_model[CAP];
  int list_len = 0;
  int errors = 0;
  int idle_pct = 24;
  int hold_cmds = 0;
  bit stim_done = 0;
  int quiet_cycles = 0;

  function automatic reply_t apply_command(cmd_t c);
    reply_t r;
    int p;
    logic signed [15:0] key;
    int j;
    longint s;
    r = '0;
    r.st = ST_DONE;
    p = c.pos;
    case (action_t'(c.act))
      ACT_INSERT: begin
        if (list_len >= CAP) r.st = ST_BAD;
        else if (list_len == 0) begin
          list_model[0] = c.score;
          list_len = 1;
        end else if (p < 1 || p > list_len + 1) r.st = ST_BAD;
        else begin
          for (int i = list_len; i >= p; i--) list_model[i] = list_model[i-1];
          list_model[p-1] = c.score;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (list_len == 0) r.st = ST_EMPTY;
        else if (p < 1 || p > list_len) r.st = ST_BAD;
        else begin
          for (int i = p; i < list_len; i++) list_model[i-1] = list_model[i];
          list_len--;
        end
      end
      ACT_SORT: begin
        for (int i = 1; i < list_len; i++) begin
          key = list_model[i];
          j = i;
          while (j > 0 && list_model[j-1] > key) begin
            list_model[j] = list_model[j-1];
            j--;
          end
          list_model[j] = key;
        end
      end
      default: begin
        if (list_len == 0) r.st = ST_EMPTY;
        else if (p < 1 || p > list_len) r.st = ST_BAD;
        else r.rd = list_model[p-1];
      end
    endcase
    r.cnt = list_len;
    if (list_len > 0) begin
      s = 0;
      r.mx = list_model[0];
      for (int i = 0; i < list_len; i++) begin
        if (list_model[i] > r.mx) r.mx = list_model[i];
        s += list_model[i];
      end
      r.sum = s;
      r.avg = (s * 256) / list_len;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      start <= 1'b0;
    end else if (!start && !busy && hold_cmds == 0 && pending_cmds.size() > 0
                 && $urandom_range(99) >= idle_pct) begin
      cmd_t c;
      c = pending_cmds.pop_front();
      if (c.act == 2'b11 && c.pos == 7'h7f && c.score == 16'sh7fff) begin
        hold_cmds = 1;
      end else begin
        action <= c.act;
        position <= c.pos;
        score_in <= c.score;
        start <= 1'b1;
      end
    end
    if (hold_cmds != 0 && expected_replies.size() == 0 && !busy && !start)
      hold_cmds = 0;
  end

  always @(posedge clk) begin
    if (!rst && start && !busy)
      expected_replies.push_back(apply_command(cmd_t'{action, position, score_in}));
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: status %0d", status);
      end else begin
        want = expected_replies.pop_front();
        if (status !== want.st || score_out !== want.rd || entry_total !== want.cnt
            || max_score !== want.mx || score_sum !== want.sum
            || average_q8 !== want.avg) begin
          errors++;
          if (errors <= 10)
            $display("exp st%0d rd%0d n%0d mx%0d sum%0d avg%0d got st%0d rd%0d n%0d mx%0d sum%0d avg%0d",
                     want.st, want.rd, want.cnt, want.mx, want.sum, want.avg, status,
                     score_out, entry_total, max_score, score_sum, average_q8);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("positional_score_list_engine: mismatch");
      $finish;
    end
  end

  task automatic add_cmd(action_t a, int p, int s);
    pending_cmds.push_back(cmd_t'{a, 7'(p), 16'(s)});
  endtask

  initial begin
    int depth;
    int a;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    add_cmd(ACT_DELETE, 1, 0);
    add_cmd(ACT_READ, 1, 0);
    add_cmd(ACT_SORT, 1, 0);
    add_cmd(ACT_INSERT, 99, -32768);
    add_cmd(ACT_DELETE, 1, 0);
    add_cmd(ACT_INSERT, 0, 32767);
    add_cmd(ACT_INSERT, 1, -32768);
    add_cmd(ACT_INSERT, 3, 16'h5555);
    add_cmd(ACT_INSERT, 5, 1);
    add_cmd(ACT_INSERT, 0, 1);
    add_cmd(ACT_READ, 0, 0);
    add_cmd(ACT_READ, 4, 0);
    add_cmd(ACT_READ, 127, 0);
    add_cmd(ACT_READ, 3, 0);
    add_cmd(ACT_SORT, 0, 0);
    add_cmd(ACT_READ, 1, 0);
    add_cmd(ACT_DELETE, 0, 0);
    add_cmd(ACT_DELETE, 4, 0);
    add_cmd(ACT_DELETE, 2, 0);
    add_cmd(ACT_SORT, 0, 0);
    pending_cmds.push_back(cmd_t'{2'b11, 7'h7f, 16'sh7fff});
    for (int i = 0; i < 66; i++) add_cmd(ACT_INSERT, 1, i[0] ? 32767 : -32768);
    add_cmd(ACT_SORT, 0, 0);
    add_cmd(ACT_READ, 64, 0);
    add_cmd(ACT_READ, 65, 0);
    add_cmd(ACT_DELETE, 65, 0);
    add_cmd(ACT_INSERT, 65, 7);
    for (int i = 0; i < 64; i++) add_cmd(ACT_DELETE, 1, 0);
    depth = 0;
    for (int n = 0; n < 350; n++) begin
      a = $urandom_range(99);
      if (n > 150 && n < 230) idle_pct = 0; else idle_pct = 24;
      if (a < 40 && depth < 64) begin
        add_cmd(ACT_INSERT, $urandom_range(95) < 90 ? $urandom_range(depth + 1, 1)
                : $urandom_range(127), $urandom);
        if (depth < 64) depth++;
      end else if (a < 65) begin
        add_cmd(ACT_DELETE, $urandom_range(95) < 90 ? $urandom_range(depth > 0 ? depth : 1, 1)
                : $urandom_range(127), $urandom);
        if (depth > 0) depth--;
      end else if (a < 72) add_cmd(ACT_SORT, $urandom_range(127), $urandom);
      else add_cmd(ACT_READ, $urandom_range(95) < 90 ? $urandom_range(depth > 0 ? depth : 1, 1)
                   : $urandom_range(127), $urandom);
      if (n == 300) pending_cmds.push_back(cmd_t'{2'b11, 7'h7f, 16'sh7fff});
      while (pending_cmds.size() > 8) @(posedge clk);
    end
    while (pending_cmds.size() > 0 || start || busy || expected_replies.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0)
      $display("positional_score_list_engine: match");
    else
      $display("positional_score_list_engine: mismatch");
    $finish;
  end
endmodule

// File: files.f
rtl/core/psle_pkg.sv
rtl/core/psle_div.sv
rtl/core/positional_score_list_engine.sv
tb/tb_positional_score_list_engine.sv
